FILE: rtl/bsce_pkg.sv
package bsce_pkg;

   localparam int ALG_WIDTH   = 4;
   localparam int CHECK_WIDTH = 32;
   localparam int BYTE_WIDTH  = 8;

   typedef logic [ALG_WIDTH-1:0]   alg_type;
   typedef logic [CHECK_WIDTH-1:0] check_type;
   typedef logic [BYTE_WIDTH-1:0]  byte_type;

   // algorithm selector codes
   localparam alg_type ALG_CRC8   = 4'd0;
   localparam alg_type ALG_CRC16  = 4'd1;
   localparam alg_type ALG_CRC32  = 4'd2;
   localparam alg_type ALG_SUM8   = 4'd3;
   localparam alg_type ALG_SUM16  = 4'd4;
   localparam alg_type ALG_XOR8   = 4'd5;
   localparam alg_type ALG_LRC8   = 4'd6;
   localparam alg_type ALG_FLET16 = 4'd7;
   localparam alg_type ALG_FLET32 = 4'd8;

   // register map, word index taken from paddr[2]
   typedef logic reg_index_type;
   localparam reg_index_type REG_ALGORITHM = 1'b0;

   localparam alg_type ALG_RESET = ALG_CRC32;

   localparam logic [7:0]  CRC8_POLY  = 8'h07;
   localparam logic [15:0] CRC16_POLY = 16'hA001;
   localparam logic [31:0] CRC32_POLY = 32'hEDB88320;
   localparam logic [8:0]  FLET16_MOD = 9'd255;
   localparam logic [16:0] FLET32_MOD = 17'd65535;

   typedef struct packed {
      logic    wr;      // register write this cycle
      alg_type wr_alg;  // value being written
      alg_type alg;     // current selector
   } cfg_type;

   typedef struct packed {
      logic     valid;
      byte_type data;
      logic     last;
   } step_type;

   function automatic check_type init_value(input alg_type alg);
      check_type v;
      v = '0;
      if (alg == ALG_CRC16) v = 32'h0000_FFFF;
      if (alg == ALG_CRC32) v = 32'hFFFF_FFFF;
      return v;
   endfunction

   function automatic logic [7:0] crc8_byte(input logic [7:0] r_in, input byte_type b);
      logic [7:0] r;
      r = r_in ^ b;
      for (int i = 0; i < 8; i++) begin
         r = r[7] ? ((r << 1) ^ CRC8_POLY) : (r << 1);
      end
      return r;
   endfunction

   function automatic logic [15:0] crc16_byte(input logic [15:0] r_in, input byte_type b);
      logic [15:0] r;
      r = r_in ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         r = r[0] ? ((r >> 1) ^ CRC16_POLY) : (r >> 1);
      end
      return r;
   endfunction

   function automatic logic [31:0] crc32_byte(input logic [31:0] r_in, input byte_type b);
      logic [31:0] r;
      r = r_in ^ {24'h000000, b};
      for (int i = 0; i < 8; i++) begin
         r = r[0] ? ((r >> 1) ^ CRC32_POLY) : (r >> 1);
      end
      return r;
   endfunction

endpackage

FILE: rtl/bsce_ifs.sv
interface bsce_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bsce_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] check_value;
   modport source (output valid, output check_value, input ready);
   modport sink (input valid, input check_value, output ready);
endinterface

FILE: rtl/byte_stream_checksum_engine_core.sv
// Each accepted byte enters the input register; a last byte then loads its result into the result register.
// Throughput: one byte per cycle unless stalled; input register -> byte update (8 CRC steps unrolled) -> result.
// A last byte waits in the input register only while an untaken result occupies the output.
// Reset (synchronous, active high): algorithm = crc32, running state at its initial value,
// both pipeline registers empty.
module byte_stream_checksum_engine_core (
   input  logic              clock,
   input  logic              reset,
   bsce_req_if.sink          req_bus,
   bsce_rsp_if.source        rsp_bus,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import bsce_pkg::*;

   // input register
   logic      s1_valid_ff, s1_valid_in;
   byte_type  s1_byte_ff, s1_byte_in;
   logic      s1_last_ff, s1_last_in;
   logic      s1_advance;

   // result register
   logic      rsp_valid_ff, rsp_valid_in;
   check_type rsp_data_ff, rsp_data_in;
   logic      rsp_load;

   cfg_type   cfg;
   step_type  step;
   check_type check_value;

   bsce_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg_o   (cfg)
   );

   // a non-last byte never needs the result slot; a last byte needs it free or draining
   assign s1_advance = s1_valid_ff & (~s1_last_ff | ~rsp_valid_ff | rsp_bus.ready);
   assign rsp_load   = s1_advance & s1_last_ff;

   assign req_bus.ready = ~s1_valid_ff | s1_advance;

   assign step.valid = s1_advance;
   assign step.data  = s1_byte_ff;
   assign step.last  = s1_last_ff;

   bsce_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .cfg_i   (cfg),
      .step_i  (step),
      .check_o (check_value)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      s1_last_in  = s1_last_ff;
      if (req_bus.ready) begin
         s1_valid_in = req_bus.valid;
         s1_byte_in  = req_bus.data_byte;
         s1_last_in  = req_bus.last_byte;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_bus.ready;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = check_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      s1_byte_ff  <= s1_byte_in;
      s1_last_ff  <= s1_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.check_value = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_last_ff))
      else $error("result appeared without a last byte");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> (s1_valid_ff && $stable(s1_byte_ff) && $stable(s1_last_ff)))
      else $error("stalled byte lost or changed");

   a_s1_capture: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> s1_valid_ff)
      else $error("accepted transaction not captured");
`endif

endmodule

FILE: rtl/bsce_csr.sv
module bsce_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [2:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready,
   output bsce_pkg::cfg_type      cfg_o
);
   import bsce_pkg::*;

   alg_type       alg_ff;
   alg_type       alg_in;
   logic          wr_alg;
   reg_index_type index;

   assign index  = paddr[2];
   assign pready = 1'b1;

   always_comb begin
      wr_alg = 1'b0;
      prdata = '0;
      unique case (index)
         REG_ALGORITHM: begin
            wr_alg = psel & penable & pwrite;
            prdata = {{(32-ALG_WIDTH){1'b0}}, alg_ff};
         end
         default: begin
            wr_alg = 1'b0;
            prdata = '0;
         end
      endcase
   end

   assign alg_in = wr_alg ? pwdata[ALG_WIDTH-1:0] : alg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alg_ff <= ALG_RESET;
      end else begin
         alg_ff <= alg_in;
      end
   end

   assign cfg_o.wr     = wr_alg;
   assign cfg_o.wr_alg = pwdata[ALG_WIDTH-1:0];
   assign cfg_o.alg    = alg_ff;

endmodule

FILE: rtl/bsce_accum.sv
module bsce_accum (
   input  logic                 clock,
   input  logic                 reset,
   input  bsce_pkg::cfg_type    cfg_i,
   input  bsce_pkg::step_type   step_i,
   output bsce_pkg::check_type  check_o
);
   import bsce_pkg::*;

   check_type   running_ff, running_in, running_nx;
   logic [15:0] second_ff, second_in, second_nx;
   logic [8:0]  f16_a, f16_b;
   logic [16:0] f32_a, f32_b;
   logic [8:0]  f16_a_red;
   logic [16:0] f32_a_red;

   // Fletcher sums: operands never exceed the modulus, so one subtract reduces
   always_comb begin
      f16_a     = {1'b0, running_ff[7:0]} + {1'b0, step_i.data};
      f16_a_red = (f16_a >= FLET16_MOD) ? (f16_a - FLET16_MOD) : f16_a;
      f16_b     = {1'b0, second_ff[7:0]} + f16_a_red;
      f32_a     = {1'b0, running_ff[15:0]} + {9'd0, step_i.data};
      f32_a_red = (f32_a >= FLET32_MOD) ? (f32_a - FLET32_MOD) : f32_a;
      f32_b     = {1'b0, second_ff} + f32_a_red;
   end

   always_comb begin
      running_nx = '0;
      second_nx  = '0;
      case (cfg_i.alg)
         ALG_CRC8:  running_nx = {24'd0, crc8_byte(running_ff[7:0], step_i.data)};
         ALG_CRC16: running_nx = {16'd0, crc16_byte(running_ff[15:0], step_i.data)};
         ALG_CRC32: running_nx = crc32_byte(running_ff, step_i.data);
         ALG_SUM8, ALG_LRC8: running_nx = {24'd0, running_ff[7:0] + step_i.data};
         ALG_SUM16: running_nx = {16'd0, running_ff[15:0] + {8'd0, step_i.data}};
         ALG_XOR8:  running_nx = {24'd0, running_ff[7:0] ^ step_i.data};
         ALG_FLET16: begin
            running_nx = {24'd0, f16_a_red[7:0]};
            second_nx  = {8'd0, (f16_b >= FLET16_MOD) ? 8'(f16_b - FLET16_MOD) : f16_b[7:0]};
         end
         ALG_FLET32: begin
            running_nx = {16'd0, f32_a_red[15:0]};
            second_nx  = (f32_b >= FLET32_MOD) ? 16'(f32_b - FLET32_MOD) : f32_b[15:0];
         end
         default: begin
            running_nx = '0;
            second_nx  = '0;
         end
      endcase
   end

   // finished value from the state after this byte
   always_comb begin
      check_o = '0;
      case (cfg_i.alg)
         ALG_CRC8, ALG_SUM8, ALG_XOR8: check_o = {24'd0, running_nx[7:0]};
         ALG_CRC16, ALG_SUM16:         check_o = {16'd0, running_nx[15:0]};
         ALG_CRC32:                    check_o = ~running_nx;
         ALG_LRC8:                     check_o = {24'd0, 8'(8'd0 - running_nx[7:0])};
         ALG_FLET16: check_o = {16'd0, second_nx[7:0], running_nx[7:0]};
         ALG_FLET32: check_o = {second_nx, running_nx[15:0]};
         default:    check_o = '0;
      endcase
   end

   always_comb begin
      running_in = running_ff;
      second_in  = second_ff;
      if (cfg_i.wr) begin
         running_in = init_value(cfg_i.wr_alg);
         second_in  = '0;
      end else if (step_i.valid) begin
         if (step_i.last) begin
            running_in = init_value(cfg_i.alg);
            second_in  = '0;
         end else begin
            running_in = running_nx;
            second_in  = second_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= init_value(ALG_RESET);
         second_ff  <= '0;
      end else begin
         running_ff <= running_in;
         second_ff  <= second_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_flet16_range: assert property (@(posedge clock) disable iff (reset)
      (cfg_i.alg == ALG_FLET16) |-> (running_ff < 32'd255 && second_ff < 16'd255))
      else $error("fletcher16 sums out of range");

   a_flet32_range: assert property (@(posedge clock) disable iff (reset)
      (cfg_i.alg == ALG_FLET32) |-> (running_ff < 32'd65535 && second_ff != 16'hFFFF))
      else $error("fletcher32 sums out of range");

   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      (cfg_i.alg > ALG_FLET32) |-> (running_ff == '0 && second_ff == '0))
      else $error("state not zero under undefined selector");
`endif

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
   import bsce_pkg::*;

   localparam int CLOCK_HALF      = 6;
   localparam int RESET_CYCLES    = 3;
   localparam int SETTLE_CYCLES   = 4;
   localparam int RSP_HOLD_CYCLES = 64;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int PHASE_COUNT     = 14;
   localparam int PHASE_BYTES     = 50;
   localparam int REPORT_LIMIT    = 10;

   // polynomials and moduli of the predictor
   localparam logic [7:0]  CRC8_TAPS    = 8'h07;
   localparam logic [15:0] CRC16_TAPS   = 16'hA001;
   localparam logic [31:0] CRC32_TAPS   = 32'hEDB8_8320;
   localparam int unsigned FL16_MODULUS = 255;
   localparam int unsigned FL32_MODULUS = 65535;

   // word index with no register behind it; writes there are dropped
   localparam reg_index_type REG_UNMAPPED = 1'b1;

   // selector codes with no algorithm: bytes go in, every check value is zero
   localparam alg_type ALG_UNDEF_LOW  = 4'd9;
   localparam alg_type ALG_UNDEF_HIGH = 4'd15;

   typedef enum logic {ROW_BYTE, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      reg_index_type index;         // ROW_WRITE only
      logic [31:0]   word;          // ROW_WRITE only
      byte_type      data;          // ROW_BYTE only
      logic          last;
      logic          pinned;        // expected check value typed in below
      check_type     pinned_value;
   } plan_row_type;

   typedef enum {RSP_FREE, RSP_COIN, RSP_COMB} rsp_mode_type;

   localparam int PLAN_ROWS = 38;

   // Directed opening. Rows without a pinned value are checked by the predictor.
   plan_row_type directed_plan [PLAN_ROWS] = '{
      // crc32 straight out of reset: one zero byte
      '{ROW_BYTE,  REG_ALGORITHM, 32'h0, 8'h00, 1'b1, 1'b1, 32'hD202_EF8D},
      '{ROW_BYTE,  REG_ALGORITHM, 32'h0, 8'hFF, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE,  REG_ALGORITHM, 32'h0, 8'h5A, 1'b1, 1'b0, 32'h0},
      // left open, the write below abandons it
      '{ROW_BYTE,  REG_ALGORITHM, 32'h0, 8'h37, 1'b0, 1'b0, 32'h0},
      '{ROW_WRITE, REG_ALGORITHM, 32'(ALG_CRC8), 8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE,  REG_ALGORITHM, 32'h0, 8'h00, 1'b1, 1'b1, 32'h0000_0000},
      '{ROW_BYTE,  REG_ALGORITHM, 32'h0, 8'hFF, 1'b1, 1'b0, 32'h0},
      '{ROW_WRITE, REG_ALGORITHM, 32'(ALG_CRC16), 8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE,  REG_ALGORITHM, 32'h0, 8'hFF, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE,  REG_ALGORITHM, 32'h0, 8'h00, 1'b1, 1'b0, 32'h0},
      // 8-bit sum wraps to zero, then to 0xFE
      '{ROW_WRITE, REG_ALGORITHM, 32'(ALG_SUM8), 8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE,  REG_ALGORITHM, 32'h0, 8'hFF, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE,  REG_ALGORITHM, 32'h0, 8'h01, 1'b1, 1'b1, 32'h0000_0000},
      '{ROW_BYTE,  REG_ALGORITHM, 32'h0, 8'hFF, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE,  REG_ALGORITHM, 32'h0, 8'hFF, 1'b1, 1'b1, 32'h0000_00FE},
      '{ROW_WRITE, REG_ALGORITHM, 32'(ALG_SUM16), 8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE,  REG_ALGORITHM, 32'h0, 8'hFF, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE,  REG_ALGORITHM, 32'h0, 8'hFF, 1'b1, 1'b1, 32'h0000_01FE},
      '{ROW_WRITE, REG_ALGORITHM, 32'(ALG_XOR8), 8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE,  REG_ALGORITHM, 32'h0, 8'hA5, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE,  REG_ALGORITHM, 32'h0, 8'h5A, 1'b1, 1'b1, 32'h0000_00FF},
      '{ROW_WRITE, REG_ALGORITHM, 32'(ALG_LRC8), 8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE,  REG_ALGORITHM, 32'h0, 8'h01, 1'b1, 1'b1, 32'h0000_00FF},
      '{ROW_BYTE,  REG_ALGORITHM, 32'h0, 8'h00, 1'b1, 1'b1, 32'h0000_0000},
      // fletcher16: 0xFF folds straight back to zero
      '{ROW_WRITE, REG_ALGORITHM, 32'(ALG_FLET16), 8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE,  REG_ALGORITHM, 32'h0, 8'hFF, 1'b1, 1'b1, 32'h0000_0000},
      '{ROW_BYTE,  REG_ALGORITHM, 32'h0, 8'h01, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE,  REG_ALGORITHM, 32'h0, 8'h02, 1'b1, 1'b1, 32'h0000_0403},
      '{ROW_WRITE, REG_ALGORITHM, 32'(ALG_FLET32), 8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE,  REG_ALGORITHM, 32'h0, 8'hFF, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE,  REG_ALGORITHM, 32'h0, 8'hFF, 1'b1, 1'b1, 32'h02FD_01FE},
      // write to the unmapped word: selector must stay fletcher32
      '{ROW_WRITE, REG_UNMAPPED,  32'h0, 8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE,  REG_ALGORITHM, 32'h0, 8'h10, 1'b1, 1'b0, 32'h0},
      // undefined selectors, both ends of the range
      '{ROW_WRITE, REG_ALGORITHM, 32'(ALG_UNDEF_HIGH), 8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE,  REG_ALGORITHM, 32'h0, 8'hFF, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE,  REG_ALGORITHM, 32'h0, 8'h80, 1'b1, 1'b1, 32'h0000_0000},
      '{ROW_WRITE, REG_ALGORITHM, 32'(ALG_UNDEF_LOW), 8'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE,  REG_ALGORITHM, 32'h0, 8'h00, 1'b1, 1'b1, 32'h0000_0000}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   bsce_req_if req_bus ();
   bsce_rsp_if rsp_bus ();

   byte_stream_checksum_engine_core uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // predictor state
   alg_type     active_alg;
   check_type   run_value;
   logic [15:0] second_sum;

   check_type   pending_checks [$];       // check values owed by the block, oldest first
   int          mismatch_count = 0;
   int          cycle_count    = 0;
   int          burst_left     = 0;
   int          holds_asked    = 0;       // sender asks, receiver counts off the hold
   int          holds_done     = 0;
   logic        rsp_holding    = 1'b0;

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   function automatic check_type start_value(input alg_type alg);
      case (alg)
         ALG_CRC16: return 32'h0000_FFFF;
         ALG_CRC32: return 32'hFFFF_FFFF;     // crc32 register is kept inverted
         default:   return '0;
      endcase
   endfunction

   function automatic void restart_check();
      run_value  = start_value(active_alg);
      second_sum = '0;
   endfunction

   // Fold one byte into the running check; on the last byte hand back the
   // finished value and start over.
   function automatic void fold_byte(input byte_type b, input logic is_last,
                                     output logic produced, output check_type value);
      logic [7:0]  r8;
      logic [15:0] r16;
      logic [31:0] r32;
      int unsigned s1;
      int unsigned s2;
      r8  = run_value[7:0] ^ b;
      r16 = run_value[15:0] ^ {8'h00, b};
      r32 = run_value ^ {24'h000000, b};
      case (active_alg)
         ALG_CRC8: begin
            for (int i = 0; i < 8; i++) r8 = r8[7] ? ((r8 << 1) ^ CRC8_TAPS) : (r8 << 1);
            run_value = {24'h000000, r8};
         end
         ALG_CRC16: begin
            for (int i = 0; i < 8; i++) r16 = r16[0] ? ((r16 >> 1) ^ CRC16_TAPS) : (r16 >> 1);
            run_value = {16'h0000, r16};
         end
         ALG_CRC32: begin
            for (int i = 0; i < 8; i++) r32 = r32[0] ? ((r32 >> 1) ^ CRC32_TAPS) : (r32 >> 1);
            run_value = r32;
         end
         ALG_SUM8, ALG_LRC8: run_value = {24'h000000, run_value[7:0] + b};
         ALG_SUM16:          run_value = {16'h0000, run_value[15:0] + {8'h00, b}};
         ALG_XOR8:           run_value = {24'h000000, run_value[7:0] ^ b};
         ALG_FLET16: begin
            s1 = (run_value + b) % FL16_MODULUS;
            s2 = (second_sum + s1) % FL16_MODULUS;
            run_value  = s1;
            second_sum = s2[15:0];
         end
         ALG_FLET32: begin
            s1 = (run_value + b) % FL32_MODULUS;
            s2 = (second_sum + s1) % FL32_MODULUS;
            run_value  = s1;
            second_sum = s2[15:0];
         end
         default: begin
            run_value  = '0;
            second_sum = '0;
         end
      endcase
      produced = is_last;
      value    = '0;
      if (is_last) begin
         case (active_alg)
            ALG_CRC8, ALG_SUM8, ALG_XOR8: value = {24'h000000, run_value[7:0]};
            ALG_CRC16, ALG_SUM16:         value = {16'h0000, run_value[15:0]};
            ALG_CRC32:                    value = ~run_value;
            ALG_LRC8:                     value = {24'h000000, 8'h00 - run_value[7:0]};
            ALG_FLET16: value = {16'h0000, second_sum[7:0], run_value[7:0]};
            ALG_FLET32: value = {second_sum, run_value[15:0]};
            default:    value = '0;
         endcase
         restart_check();
      end
   endfunction

   function automatic void note_failure(input string what, input check_type want,
                                        input check_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t: %s: expected %08h, got %08h", $realtime, what, want, got);
   endfunction

   // APB write: setup cycle, then access cycle until pready
   task automatic write_reg(input reg_index_type index, input logic [31:0] word);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (index == REG_ALGORITHM) begin
         active_alg = alg_type'(word[ALG_WIDTH-1:0]);
         restart_check();
      end
   endtask

   // Offer one byte and hold it until the transaction is taken; valid stays up.
   task automatic send_byte(input byte_type b, input logic is_last,
                            input logic pinned, input check_type pinned_value);
      logic      produced;
      check_type predicted;
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.last_byte <= is_last;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      fold_byte(b, is_last, produced, predicted);
      if (produced) pending_checks.push_back(pinned ? pinned_value : predicted);
   endtask

   // Bursts of random length, random gaps between them; no gaps while the
   // receiver is holding off so the block backs up.
   task automatic pace_sender();
      int gap;
      if (rsp_holding || burst_left > 0) begin
         if (burst_left > 0) burst_left--;
         return;
      end
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 16);
   endtask

   // Block idle: nothing owed, and any trailing non-last byte has been folded.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_checks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   function automatic byte_type pick_byte(input logic heavy);
      int unsigned roll;
      roll = $urandom_range(0, 15);
      if (heavy) return (roll == 0) ? byte_type'($urandom()) : 8'hFF;
      if (roll == 0) return 8'h00;
      if (roll == 1) return 8'hFF;
      return byte_type'($urandom());
   endfunction

   // closed = 0 leaves the message open for the next register write to abandon
   task automatic send_message(input int len, input logic closed, input logic heavy);
      for (int k = 0; k < len; k++) begin
         send_byte(pick_byte(heavy), closed && (k == len - 1), 1'b0, '0);
         pace_sender();
      end
   endtask

   // Sender: reset, directed table, then random phases, one algorithm each.
   initial begin : stimulus
      int          phase_bytes;
      int          len;
      logic        heavy;
      alg_type     alg;
      logic [31:0] word;

      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.data_byte <= '0;
      req_bus.last_byte <= 1'b0;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      active_alg = ALG_RESET;
      restart_check();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_plan[n]) begin
         if (directed_plan[n].kind == ROW_WRITE) begin
            wait_drained();
            write_reg(directed_plan[n].index, directed_plan[n].word);
         end else begin
            send_byte(directed_plan[n].data, directed_plan[n].last,
                      directed_plan[n].pinned, directed_plan[n].pinned_value);
            pace_sender();
         end
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         // every defined algorithm once in order, then random picks incl. undefined
         alg  = (phase <= int'(ALG_FLET32)) ? alg_type'(phase)
                                            : alg_type'($urandom_range(0, 15));
         word = $urandom();
         word[ALG_WIDTH-1:0] = alg;
         wait_drained();
         write_reg(REG_ALGORITHM, word);
         // in one phase in four, an idle pause and then a second write, to the unmapped word
         if ($urandom_range(0, 3) == 0) begin
            @(posedge clock);
            write_reg(REG_UNMAPPED, $urandom());
         end
         // two phases run under a long receiver hold-off
         if (phase == 3 || phase == 10) holds_asked++;

         phase_bytes = 0;
         while (phase_bytes < PHASE_BYTES) begin
            heavy = 1'b0;
            if (rsp_holding) begin
               len = 1;                 // one result per byte fills the output side
            end else if ((alg == ALG_SUM16 || alg == ALG_FLET16 || alg == ALG_FLET32) &&
                         $urandom_range(0, 9) == 0) begin
               len   = $urandom_range(260, 320);    // long enough to wrap the sums
               heavy = 1'b1;
            end else begin
               len = $urandom_range(1, 12);
            end
            send_message(len, 1'b1, heavy);
            phase_bytes += len;
         end
         if ($urandom_range(0, 2) == 0) send_message($urandom_range(1, 5), 1'b0, 1'b0);
      end

      wait_drained();
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Receiver: changes stall mode at random intervals; on request holds
   // ready low for a long stretch counted here.
   initial begin : receiver
      rsp_mode_type mode;
      int           mode_left;
      int           comb_count;
      mode_left  = 0;
      comb_count = 0;
      mode       = RSP_FREE;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (holds_done != holds_asked) begin
            holds_done++;
            rsp_bus.ready <= 1'b0;
            rsp_holding   <= 1'b1;
            for (int h = 0; h < RSP_HOLD_CYCLES; h++) @(posedge clock);
            rsp_holding   <= 1'b0;
         end
         if (mode_left == 0) begin
            mode      = rsp_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         case (mode)
            RSP_FREE: rsp_bus.ready <= 1'b1;
            RSP_COIN: rsp_bus.ready <= 1'($urandom_range(0, 1));
            default: begin
               rsp_bus.ready <= (comb_count % 5) >= 2;
               comb_count++;
            end
         endcase
         @(posedge clock);
      end
   end

   // Result monitor: each transaction taken is matched against the oldest owed value.
   always @(posedge clock) begin
      check_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_checks.size() == 0) begin
            note_failure("check value with none owed", '0, rsp_bus.check_value);
         end else begin
            want = pending_checks.pop_front();
            if (rsp_bus.check_value !== want)
               note_failure("check_value mismatch", want, rsp_bus.check_value);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule
